FILE: design/mhf_pkg.sv
// Shared types, constants and hash functions for the multicast hash filter.
// Used by every module of the block; depends on nothing.
package mhf_pkg;

    // Count width per bucket and derived limits
    localparam int CNT_W       = 8;
    localparam int BUCKET_W    = 6;
    localparam int NUM_BUCKETS = 1 << BUCKET_W;
    localparam int ADDR_W      = 48;
    localparam int OCTETS      = ADDR_W / 8;
    localparam int OCT_CNT_W   = 3;
    localparam int TABLE_W     = NUM_BUCKETS;
    localparam int OUT_CNT_W   = 8;

    localparam logic [31:0] CRC_POLY   = 32'hEDB8_8320;
    localparam logic [31:0] CRC_PRESET = 32'hFFFF_FFFF;

    // Request operations
    localparam logic OP_JOIN  = 1'b0;
    localparam logic OP_LEAVE = 1'b1;

    // Result status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_UNDERFLOW = 2'd1;
    localparam logic [1:0] ST_SATURATED = 2'd2;

    typedef struct packed {
        logic                op;
        logic [BUCKET_W-1:0] bucket;
    } t_req;

    typedef enum logic [1:0] {
        FR_IDLE,
        FR_CRC,
        FR_PUSH
    } t_front_state;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_UPDATE
    } t_back_state;

    // Advance the reflected CRC-32 by one octet
    function automatic logic [31:0] crc_octet(input logic [31:0] crc, input logic [7:0] octet);
        logic [31:0] c;
        c = crc ^ {24'h0, octet};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

    // Invert the CRC, bit-reverse it and take the top bucket bits
    function automatic logic [BUCKET_W-1:0] crc_bucket(input logic [31:0] crc);
        logic [31:0]         fin;
        logic [BUCKET_W-1:0] b;
        fin = ~crc;
        for (int j = 0; j < BUCKET_W; j++) begin
            b[BUCKET_W-1-j] = fin[j];
        end
        return b;
    endfunction

endpackage

FILE: design/mhf_front.sv
// Front end: accepts join/leave requests and hashes the address, one octet
// per cycle, into a bucket index. Depends on mhf_pkg.
module mhf_front (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     start,
    output logic                     busy,
    input  logic                     i_op,
    input  logic [mhf_pkg::ADDR_W-1:0] i_mac_address,
    output logic                     o_push,
    output mhf_pkg::t_req            o_req,
    input  logic                     i_full
);

    mhf_pkg::t_front_state r_state, n_state;
    logic [31:0]                   r_crc;
    logic [mhf_pkg::ADDR_W-1:0]    r_addr;
    logic [mhf_pkg::OCT_CNT_W-1:0] r_octet;
    logic                          r_op;

    // Hold the state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mhf_pkg::FR_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and queue push
    always_comb begin
        n_state = r_state;
        o_push  = 1'b0;
        unique case (r_state)
            mhf_pkg::FR_IDLE: begin
                if (start) n_state = mhf_pkg::FR_CRC;
            end
            mhf_pkg::FR_CRC: begin
                if (r_octet == mhf_pkg::OCT_CNT_W'(mhf_pkg::OCTETS - 1)) begin
                    n_state = mhf_pkg::FR_PUSH;
                end
            end
            mhf_pkg::FR_PUSH: begin
                if (!i_full) begin
                    o_push  = 1'b1;
                    n_state = mhf_pkg::FR_IDLE;
                end
            end
            default: n_state = mhf_pkg::FR_IDLE;
        endcase
    end

    // Load the request, then shift the address through the CRC one octet a cycle
    always_ff @(posedge i_clk) begin
        if (r_state == mhf_pkg::FR_IDLE) begin
            r_crc   <= mhf_pkg::CRC_PRESET;
            r_addr  <= i_mac_address;
            r_op    <= i_op;
            r_octet <= '0;
        end else if (r_state == mhf_pkg::FR_CRC) begin
            r_crc   <= mhf_pkg::crc_octet(r_crc, r_addr[mhf_pkg::ADDR_W-1 -: 8]);
            r_addr  <= r_addr << 8;
            r_octet <= r_octet + 1'b1;
        end
    end

    assign busy         = (r_state != mhf_pkg::FR_IDLE);
    assign o_req.op     = r_op;
    assign o_req.bucket = mhf_pkg::crc_bucket(r_crc);

endmodule

FILE: design/mhf_queue.sv
// Two-entry request queue between the hashing front end and the count
// update back end. Depends on mhf_pkg.
module mhf_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  mhf_pkg::t_req i_req,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_empty,
    output mhf_pkg::t_req o_req
);

    mhf_pkg::t_req r_mem [2];
    logic          r_wr_ptr;
    logic          r_rd_ptr;
    logic [1:0]    r_fill;

    // Store pushed entries
    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wr_ptr] <= i_req;
    end

    // Advance pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_fill   <= 2'd0;
        end else begin
            if (i_push) r_wr_ptr <= ~r_wr_ptr;
            if (i_pop)  r_rd_ptr <= ~r_rd_ptr;
            r_fill <= r_fill + {1'b0, i_push} - {1'b0, i_pop};
        end
    end

    assign o_full  = (r_fill == 2'd2);
    assign o_empty = (r_fill == 2'd0);
    assign o_req   = r_mem[r_rd_ptr];

endmodule

FILE: design/mhf_back.sv
// Back end: reads the bucket reference count, applies join or leave,
// updates the filter table and issues one result. Depends on mhf_pkg.
module mhf_back (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_empty,
    input  mhf_pkg::t_req                  i_req,
    output logic                           o_pop,
    output logic                           o_strobe,
    output logic [1:0]                     o_status,
    output logic [mhf_pkg::BUCKET_W-1:0]   o_bucket,
    output logic [mhf_pkg::OUT_CNT_W-1:0]  o_bucket_count,
    output logic [mhf_pkg::TABLE_W-1:0]    o_filter_bits
);

    localparam logic [mhf_pkg::CNT_W-1:0] CntMax = '1;

    mhf_pkg::t_back_state r_state, n_state;
    logic [mhf_pkg::CNT_W-1:0]       r_mem [mhf_pkg::NUM_BUCKETS];
    logic [mhf_pkg::NUM_BUCKETS-1:0] r_vld;
    logic [mhf_pkg::CNT_W-1:0]       r_rd_data;
    logic                            r_rd_vld;
    mhf_pkg::t_req                   r_req;
    logic [mhf_pkg::TABLE_W-1:0]     r_table;
    logic                            r_strobe;
    logic [1:0]                      r_status;
    logic [mhf_pkg::CNT_W-1:0]       r_cnt_out;

    logic [mhf_pkg::CNT_W-1:0]   w_cnt;
    logic [mhf_pkg::CNT_W-1:0]   n_cnt;
    logic [1:0]                  n_status;
    logic [mhf_pkg::TABLE_W-1:0] n_table;
    logic [mhf_pkg::TABLE_W-1:0] w_bit;
    logic                        w_update;

    // Hold the state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mhf_pkg::BK_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state: pop a request, then update its bucket
    always_comb begin
        n_state  = r_state;
        o_pop    = 1'b0;
        w_update = 1'b0;
        unique case (r_state)
            mhf_pkg::BK_IDLE: begin
                if (!i_empty) begin
                    o_pop   = 1'b1;
                    n_state = mhf_pkg::BK_UPDATE;
                end
            end
            mhf_pkg::BK_UPDATE: begin
                w_update = 1'b1;
                n_state  = mhf_pkg::BK_IDLE;
            end
            default: n_state = mhf_pkg::BK_IDLE;
        endcase
    end

    // Apply join or leave to the count and the table
    always_comb begin
        w_cnt    = r_rd_vld ? r_rd_data : '0;
        w_bit    = mhf_pkg::TABLE_W'(1) << r_req.bucket;
        n_cnt    = w_cnt;
        n_status = mhf_pkg::ST_OK;
        n_table  = r_table;
        if (r_req.op == mhf_pkg::OP_JOIN) begin
            if (w_cnt == CntMax) begin
                n_status = mhf_pkg::ST_SATURATED;
            end else begin
                n_cnt = w_cnt + 1'b1;
            end
            n_table = r_table | w_bit;
        end else begin
            if (w_cnt == '0) begin
                n_status = mhf_pkg::ST_UNDERFLOW;
            end else begin
                n_cnt = w_cnt - 1'b1;
                if (n_cnt == '0) n_table = r_table & ~w_bit;
            end
        end
    end

    // Count memory: read on pop, write back on update
    always_ff @(posedge i_clk) begin
        if (o_pop) r_rd_data <= r_mem[i_req.bucket];
        if (w_update) r_mem[r_req.bucket] <= n_cnt;
    end

    // Latch the popped request and the entry's valid bit
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_req    <= i_req;
            r_rd_vld <= r_vld[i_req.bucket];
        end
    end

    // Valid bits, table and result strobe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_table  <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= w_update;
            if (w_update) begin
                r_vld[r_req.bucket] <= 1'b1;
                r_table             <= n_table;
            end
        end
    end

    // Result payload
    always_ff @(posedge i_clk) begin
        if (w_update) begin
            r_status  <= n_status;
            r_cnt_out <= n_cnt;
        end
    end

    assign o_strobe       = r_strobe;
    assign o_status       = r_status;
    assign o_bucket       = r_req.bucket;
    assign o_bucket_count = mhf_pkg::OUT_CNT_W'(r_cnt_out);
    assign o_filter_bits  = r_table;

endmodule

FILE: design/multicast_hash_filter_refcount_unit.sv
// Top level of the multicast hash filter with per-bucket reference counts.
// Instantiates mhf_front, mhf_queue and mhf_back; depends on mhf_pkg.
//
// channel   direction  handshake              payload
// request   in         start & !busy          i_op, i_mac_address
// result    out        o_strobe (one cycle)   o_status, o_bucket, o_bucket_count, o_filter_bits
//
// The front end hashes the address one octet per cycle: after a transfer busy
// stays high through the six CRC octets and the push, and a new request is taken
// only once busy falls; a full queue would hold the push longer.
// The back end serves one request at a time: it pops the queue and reads the
// count memory, then writes the update; the strobe is registered from the update.
// Reset is synchronous and clears the counts' valid bits and the table at once.
// The receiver cannot stall: each result is on the ports for one cycle.
module multicast_hash_filter_refcount_unit (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic                            i_op,
    input  logic [mhf_pkg::ADDR_W-1:0]      i_mac_address,
    output logic                            o_strobe,
    output logic [1:0]                      o_status,
    output logic [mhf_pkg::BUCKET_W-1:0]    o_bucket,
    output logic [mhf_pkg::OUT_CNT_W-1:0]   o_bucket_count,
    output logic [mhf_pkg::TABLE_W-1:0]     o_filter_bits
);

    logic          w_push;
    logic          w_full;
    logic          w_pop;
    logic          w_empty;
    mhf_pkg::t_req w_front_req;
    mhf_pkg::t_req w_head_req;

    // Hash requests
    mhf_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_op          (i_op),
        .i_mac_address (i_mac_address),
        .o_push        (w_push),
        .o_req         (w_front_req),
        .i_full        (w_full)
    );

    // Buffer hashed requests
    mhf_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_req   (w_front_req),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_empty (w_empty),
        .o_req   (w_head_req)
    );

    // Update counts and table
    mhf_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_empty        (w_empty),
        .i_req          (w_head_req),
        .o_pop          (w_pop),
        .o_strobe       (o_strobe),
        .o_status       (o_status),
        .o_bucket       (o_bucket),
        .o_bucket_count (o_bucket_count),
        .o_filter_bits  (o_filter_bits)
    );

    // A nonzero count always leaves its bucket bit set
    a_cnt_bit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_bucket_count != '0) |-> o_filter_bits[o_bucket])
        else $error("bucket count nonzero but table bit clear");

    // An ignored leave reports a zero count
    a_underflow_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_status == mhf_pkg::ST_UNDERFLOW) |-> (o_bucket_count == '0))
        else $error("underflow reported with nonzero count");

    // Never push into a full queue or pop an empty one
    a_queue_safe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_push && w_full) && !(w_pop && w_empty))
        else $error("request queue overflow or underflow");

    // An accepted request makes the front end busy
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("front end not busy after accepting a request");

endmodule

FILE: verif/tb_top.sv
`timescale 1ns / 100ps
// Self-checking bench for multicast_hash_filter_refcount_unit: join/leave requests
// are hashed and counted by a scoreboard class. Depends on mhf_pkg and the design.
module tb_top;

    localparam int COUNT_TOP   = (1 << mhf_pkg::CNT_W) - 1;
    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_WAIT  = 24;
    localparam int POOL_SIZE   = 16;
    localparam int PHASE_ITEMS = 170;
    localparam int SAT_RUN     = COUNT_TOP + 3;

    typedef struct packed {
        logic [1:0]                    status;
        logic [mhf_pkg::BUCKET_W-1:0]  bucket;
        logic [mhf_pkg::OUT_CNT_W-1:0] count;
        logic [mhf_pkg::TABLE_W-1:0]   filter_bits;
    } t_filter_result;

    // Tracks per-bucket reference counts and the filter table, and holds the
    // results the block owes us in request order.
    class t_filter_scoreboard;
        int unsigned                 bucket_refs[mhf_pkg::NUM_BUCKETS];
        logic [mhf_pkg::TABLE_W-1:0] filter_bits;
        t_filter_result              owed_results[$];
        int                          failures;

        function new();
            foreach (bucket_refs[i]) bucket_refs[i] = 0;
            filter_bits = '0;
            failures    = 0;
        endfunction

        // Reflected CRC-32 over the six octets, inverted, bit-reversed, top six bits
        function logic [mhf_pkg::BUCKET_W-1:0] bucket_of(logic [mhf_pkg::ADDR_W-1:0] mac);
            logic [31:0] crc;
            logic [31:0] flipped;
            logic [7:0]  oct;
            crc = 32'hFFFF_FFFF;
            for (int n = 0; n < mhf_pkg::OCTETS; n++) begin
                oct = mac[mhf_pkg::ADDR_W-1-8*n -: 8];
                crc = crc ^ {24'd0, oct};
                for (int k = 0; k < 8; k++) begin
                    crc = crc[0] ? ((crc >> 1) ^ 32'hEDB8_8320) : (crc >> 1);
                end
            end
            crc = ~crc;
            for (int k = 0; k < 32; k++) begin
                flipped[31-k] = crc[k];
            end
            return flipped[31:32-mhf_pkg::BUCKET_W];
        endfunction

        // Apply one accepted request and queue the result it must produce
        function void note_request(logic op, logic [mhf_pkg::ADDR_W-1:0] mac);
            logic [mhf_pkg::BUCKET_W-1:0] idx;
            logic [mhf_pkg::TABLE_W-1:0]  mask;
            logic [1:0]                   st;
            int unsigned                  cnt;
            t_filter_result               res;
            idx  = bucket_of(mac);
            mask = {{(mhf_pkg::TABLE_W-1){1'b0}}, 1'b1} << idx;
            st   = mhf_pkg::ST_OK;
            cnt  = bucket_refs[idx];
            if (op == mhf_pkg::OP_JOIN) begin
                if (cnt >= COUNT_TOP) st = mhf_pkg::ST_SATURATED;
                else cnt++;
                filter_bits = filter_bits | mask;
            end else if (cnt == 0) begin
                st = mhf_pkg::ST_UNDERFLOW;
            end else begin
                cnt--;
                if (cnt == 0) filter_bits = filter_bits & ~mask;
            end
            bucket_refs[idx]   = cnt;
            res.status         = st;
            res.bucket         = idx;
            res.count          = cnt[mhf_pkg::OUT_CNT_W-1:0];
            res.filter_bits    = filter_bits;
            owed_results.push_back(res);
        endfunction

        // Compare one strobed result with the oldest owed one
        function void check_result(logic [1:0] st, logic [mhf_pkg::BUCKET_W-1:0] idx,
                                   logic [mhf_pkg::OUT_CNT_W-1:0] cnt,
                                   logic [mhf_pkg::TABLE_W-1:0] bits);
            t_filter_result want;
            if (owed_results.size() == 0) begin
                $error("result strobe with no request outstanding");
                failures++;
                return;
            end
            want = owed_results.pop_front();
            if (st !== want.status) begin
                $error("status: expected %0d, got %0d", want.status, st);
                failures++;
            end
            if (idx !== want.bucket) begin
                $error("bucket: expected %0d, got %0d", want.bucket, idx);
                failures++;
            end
            if (cnt !== want.count) begin
                $error("bucket_count: expected %0d, got %0d", want.count, cnt);
                failures++;
            end
            if (bits !== want.filter_bits) begin
                $error("filter_bits: expected %h, got %h", want.filter_bits, bits);
                failures++;
            end
        endfunction

        function int pending();
            return owed_results.size();
        endfunction
    endclass

    logic                          i_clk;
    logic                          i_rst_n;
    logic                          start;
    logic                          busy;
    logic                          i_op;
    logic [mhf_pkg::ADDR_W-1:0]    i_mac_address;
    logic                          o_strobe;
    logic [1:0]                    o_status;
    logic [mhf_pkg::BUCKET_W-1:0]  o_bucket;
    logic [mhf_pkg::OUT_CNT_W-1:0] o_bucket_count;
    logic [mhf_pkg::TABLE_W-1:0]   o_filter_bits;

    t_filter_scoreboard            filter_sb;
    int                            idle_pct;
    int                            cycle_count = 0;
    logic [mhf_pkg::ADDR_W-1:0]    addr_pool[POOL_SIZE];

    multicast_hash_filter_refcount_unit u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_op           (i_op),
        .i_mac_address  (i_mac_address),
        .o_strobe       (o_strobe),
        .o_status       (o_status),
        .o_bucket       (o_bucket),
        .o_bucket_count (o_bucket_count),
        .o_filter_bits  (o_filter_bits)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Abort a hung run
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("tb_top: FAIL");
            $finish;
        end
    end

    // Check every strobed result against the oldest owed one
    always @(posedge i_clk) begin
        if (i_rst_n && o_strobe === 1'b1) begin
            filter_sb.check_result(o_status, o_bucket, o_bucket_count, o_filter_bits);
        end
    end

    function automatic logic [mhf_pkg::ADDR_W-1:0] random_mac();
        return {16'($urandom), 32'($urandom)};
    endfunction

    // Idle at random, then present one request and hold it until transferred
    task automatic send_request(logic op, logic [mhf_pkg::ADDR_W-1:0] mac);
        while ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start         <= 1'b1;
        i_op          <= op;
        i_mac_address <= mac;
        @(posedge i_clk);
        while (busy !== 1'b0) @(posedge i_clk);
        filter_sb.note_request(op, mac);
    endtask

    // Hold off the sender until every owed result has come back
    task automatic drain_results();
        start <= 1'b0;
        @(posedge i_clk);
        while (filter_sb.pending() != 0) @(posedge i_clk);
    endtask

    // Mostly joins and leaves over a small address pool, the rest random noise
    task automatic random_phase();
        logic [mhf_pkg::ADDR_W-1:0] mac;
        logic                       op;
        for (int n = 0; n < PHASE_ITEMS; n++) begin
            if ($urandom_range(99) < 70) begin
                mac = addr_pool[$urandom_range(POOL_SIZE-1)];
                op  = ($urandom_range(99) < 55) ? mhf_pkg::OP_JOIN : mhf_pkg::OP_LEAVE;
            end else begin
                mac = random_mac();
                op  = $urandom_range(1) ? mhf_pkg::OP_LEAVE : mhf_pkg::OP_JOIN;
            end
            send_request(op, mac);
        end
    endtask

    initial begin
        logic [mhf_pkg::ADDR_W-1:0] sat_mac;
        filter_sb     = new();
        start         = 1'b0;
        i_op          = mhf_pkg::OP_JOIN;
        i_mac_address = '0;
        i_rst_n       = 1'b0;
        idle_pct      = 0;
        foreach (addr_pool[i]) addr_pool[i] = random_mac();
        addr_pool[0] = 48'h0100_5E00_0001;
        addr_pool[1] = 48'h3333_0000_00FB;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: underflow from reset, join/leave round trip, address extremes
        send_request(mhf_pkg::OP_LEAVE, 48'h0);
        send_request(mhf_pkg::OP_JOIN,  48'h0);
        send_request(mhf_pkg::OP_JOIN,  48'h0);
        send_request(mhf_pkg::OP_LEAVE, 48'h0);
        send_request(mhf_pkg::OP_LEAVE, 48'h0);
        send_request(mhf_pkg::OP_LEAVE, 48'h0);
        send_request(mhf_pkg::OP_JOIN,  48'hFFFF_FFFF_FFFF);
        send_request(mhf_pkg::OP_JOIN,  48'h0100_5E00_0001);
        send_request(mhf_pkg::OP_JOIN,  48'h3333_0000_0001);
        send_request(mhf_pkg::OP_JOIN,  48'hAAAA_AAAA_AAAA);
        send_request(mhf_pkg::OP_JOIN,  48'h5555_5555_5555);
        send_request(mhf_pkg::OP_JOIN,  48'h8000_0000_0000);
        send_request(mhf_pkg::OP_JOIN,  48'h0000_0000_0001);
        send_request(mhf_pkg::OP_LEAVE, 48'hFFFF_FFFF_FFFF);
        send_request(mhf_pkg::OP_LEAVE, 48'hFFFF_FFFF_FFFF);
        send_request(mhf_pkg::OP_LEAVE, 48'hAAAA_AAAA_AAAA);
        send_request(mhf_pkg::OP_LEAVE, 48'h5555_5555_5555);
        send_request(mhf_pkg::OP_LEAVE, 48'h0100_5E00_0001);
        drain_results();

        // Random phases: sender idles often, then more often, then never
        for (int phase = 0; phase < 3; phase++) begin
            idle_pct = (phase == 0) ? 29 : (phase == 1) ? 55 : 0;
            random_phase();
            if (phase == 2) begin
                // Drive one bucket into saturation, then back past zero
                sat_mac = random_mac();
                for (int n = 0; n < SAT_RUN; n++) send_request(mhf_pkg::OP_JOIN, sat_mac);
                for (int n = 0; n < SAT_RUN; n++) send_request(mhf_pkg::OP_LEAVE, sat_mac);
            end
            drain_results();
        end

        // Let any stray strobe show up before deciding
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (filter_sb.failures == 0 && filter_sb.pending() == 0) begin
            $display("tb_top: PASS");
        end else begin
            $display("tb_top: FAIL");
        end
        $finish;
    end

endmodule
